// File: design/compass_heading_hard_iron_macros.svh
// assertion macros shared by the compass heading checker
// no dependencies; include by bare file name
`ifndef COMPASS_HEADING_HARD_IRON_MACROS_SVH
`define COMPASS_HEADING_HARD_IRON_MACROS_SVH

// condition must hold at every edge out of reset
`define CHHI_ASSERT_NOW(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHHI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/chhi_pkg.sv
// types, widths and the cordic angle table for the compass heading block
// no dependencies
`default_nettype none

package chhi_pkg;

  localparam int unsigned CORDIC_STEPS   = 16;
  localparam int unsigned ATAN_TABLE_LEN = 24;
  localparam int unsigned NUM_STEPS      =
    (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned NRM_W   = 18;  // 2*raw - max - min
  localparam int unsigned RNG_W   = 17;  // max - min when positive
  localparam int unsigned PROD_W  = 36;
  localparam int unsigned XY_W    = 38;  // headroom for cordic gain
  localparam int unsigned Z_W     = 26;  // degrees in q16
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned HEAD_W  = 9;
  localparam int unsigned DEG_W   = Z_W - FRAC_W;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic signed [Z_W-1:0]    Z_HALF_TURN  = Z_W'(180 * 65536);
  localparam logic [DEG_W-1:0]         DEG_LIMIT    = DEG_W'(180);
  localparam logic signed [HEAD_W-1:0] HEAD_ZERO    = '0;
  localparam logic signed [HEAD_W-1:0] HEAD_HALF    = HEAD_W'(180);

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading_deg;
    logic                     range_error;
  } out_item_t;

  // side cases that bypass the cordic result
  typedef struct packed {
    logic err;
    logic y_zero;
    logic x_neg;
  } flags_t;

  // atan(2^-i) in degrees, q16, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = Z_W'(2949120);
      1:  r = Z_W'(1740967);
      2:  r = Z_W'(919879);
      3:  r = Z_W'(466945);
      4:  r = Z_W'(234379);
      5:  r = Z_W'(117304);
      6:  r = Z_W'(58666);
      7:  r = Z_W'(29335);
      8:  r = Z_W'(14668);
      9:  r = Z_W'(7334);
      10: r = Z_W'(3667);
      11: r = Z_W'(1833);
      12: r = Z_W'(917);
      13: r = Z_W'(458);
      14: r = Z_W'(229);
      15: r = Z_W'(115);
      16: r = Z_W'(57);
      17: r = Z_W'(29);
      18: r = Z_W'(14);
      19: r = Z_W'(7);
      20: r = Z_W'(4);
      21: r = Z_W'(2);
      22: r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/compass_heading_hard_iron.sv
// compass heading with hard-iron offset removal, pipelined vectoring cordic
// depends on chhi_pkg
//
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_stall_o    in_data_i   (raw_x, raw_y)
// out       out  out_valid_o / out_stall_i  out_data_o  (heading_deg, range_error)
// cfg       in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one item per cycle; the registered stages, in order:
// normalize, multiply, half-plane fold, one cordic iteration per stage, truncation.
// the whole pipeline advances together; it holds only while the output item is
// stalled, and the output register lets in a new item whenever it is taken.
// reset clears the valid bits and loads the default calibration.
`default_nettype none

module compass_heading_hard_iron (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire chhi_pkg::in_item_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output chhi_pkg::out_item_t                    out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [chhi_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [chhi_pkg::PDATA_W-1:0]      pwdata,
  output logic [chhi_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);

  localparam int unsigned NS = chhi_pkg::NUM_STEPS;

  // calibration registers
  logic signed [chhi_pkg::RAW_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic                              cfg_wr;
  chhi_pkg::reg_idx_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = chhi_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= -16'sd354;
      x_max_q <= 16'sd414;
      y_min_q <= -16'sd909;
      y_max_q <= -16'sd551;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        chhi_pkg::REG_X_MIN: x_min_q <= pwdata[15:0];
        chhi_pkg::REG_X_MAX: x_max_q <= pwdata[15:0];
        chhi_pkg::REG_Y_MIN: y_min_q <= pwdata[15:0];
        chhi_pkg::REG_Y_MAX: y_max_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      chhi_pkg::REG_X_MIN: prdata = chhi_pkg::PDATA_W'(x_min_q);
      chhi_pkg::REG_X_MAX: prdata = chhi_pkg::PDATA_W'(x_max_q);
      chhi_pkg::REG_Y_MIN: prdata = chhi_pkg::PDATA_W'(y_min_q);
      chhi_pkg::REG_Y_MAX: prdata = chhi_pkg::PDATA_W'(y_max_q);
      default:             prdata = '0;
    endcase
  end

  // pipeline control
  logic                out_valid_q;
  chhi_pkg::out_item_t out_q;
  logic                adv;
  logic [NS+2:0]       vld_q;   // 0: normalize, 1: multiply, 2+k: cordic input k

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NS+1:0], in_valid_i};
      out_valid_q <= vld_q[NS+2];
    end
  end

  chhi_pkg::flags_t fl_q [0:NS+2];

  // stage a: center on the calibration midpoint and form the ranges
  logic signed [chhi_pkg::NRM_W-1:0] nx_d, ny_d, dx_d, dy_d;
  logic signed [chhi_pkg::NRM_W-1:0] nx_q, ny_q;
  logic        [chhi_pkg::RNG_W-1:0] dx_q, dy_q;
  chhi_pkg::flags_t                  fa_d;

  always_comb begin
    nx_d = (chhi_pkg::NRM_W'(in_data_i.raw_x) <<< 1)
         - chhi_pkg::NRM_W'(x_max_q) - chhi_pkg::NRM_W'(x_min_q);
    ny_d = (chhi_pkg::NRM_W'(in_data_i.raw_y) <<< 1)
         - chhi_pkg::NRM_W'(y_max_q) - chhi_pkg::NRM_W'(y_min_q);
    dx_d = chhi_pkg::NRM_W'(x_max_q) - chhi_pkg::NRM_W'(x_min_q);
    dy_d = chhi_pkg::NRM_W'(y_max_q) - chhi_pkg::NRM_W'(y_min_q);
    fa_d.err    = dx_d[chhi_pkg::NRM_W-1] || (dx_d == '0)
               || dy_d[chhi_pkg::NRM_W-1] || (dy_d == '0);
    fa_d.y_zero = (ny_d == '0);
    fa_d.x_neg  = nx_d[chhi_pkg::NRM_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q     <= nx_d;
      ny_q     <= ny_d;
      dx_q     <= dx_d[chhi_pkg::RNG_W-1:0];
      dy_q     <= dy_d[chhi_pkg::RNG_W-1:0];
      fl_q[0]  <= fa_d;
    end
  end

  // stage b: cross-scale so that atan2(ny/dy, nx/dx) = atan2(ny*dx, nx*dy)
  logic signed [chhi_pkg::PROD_W-1:0] xm_q, ym_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xm_q    <= nx_q * $signed({1'b0, dy_q});
      ym_q    <= ny_q * $signed({1'b0, dx_q});
      fl_q[1] <= fl_q[0];
    end
  end

  // stage c: fold the left half-plane by a half turn
  logic signed [chhi_pkg::XY_W-1:0] cx_q [0:NS];
  logic signed [chhi_pkg::XY_W-1:0] cy_q [0:NS];
  logic signed [chhi_pkg::Z_W-1:0]  cz_q [0:NS];
  logic signed [chhi_pkg::XY_W-1:0] xe, ye;
  logic                             xm_neg, ym_pos;

  always_comb begin
    xe     = chhi_pkg::XY_W'(xm_q);
    ye     = chhi_pkg::XY_W'(ym_q);
    xm_neg = xm_q[chhi_pkg::PROD_W-1];
    ym_pos = !ym_q[chhi_pkg::PROD_W-1] && (ym_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= xm_neg ? -xe : xe;
      cy_q[0] <= xm_neg ? -ye : ye;
      if (!xm_neg) begin
        cz_q[0] <= '0;
      end else begin
        cz_q[0] <= ym_pos ? chhi_pkg::Z_HALF_TURN : -chhi_pkg::Z_HALF_TURN;
      end
      fl_q[2] <= fl_q[1];
    end
  end

  // cordic: one vectoring iteration per stage, y driven toward zero
  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [chhi_pkg::XY_W-1:0] xs, ys;
    logic                             y_pos;

    assign xs    = cx_q[i] >>> i;
    assign ys    = cy_q[i] >>> i;
    assign y_pos = !cy_q[i][chhi_pkg::XY_W-1] && (cy_q[i] != '0);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (y_pos) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + chhi_pkg::atan_q16(i);
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - chhi_pkg::atan_q16(i);
        end
        fl_q[i+3] <= fl_q[i+2];
      end
    end
  end

  // output stage: truncate toward zero, clamp, apply side cases
  logic                             z_neg;
  logic [chhi_pkg::Z_W-1:0]         z_mag;
  logic [chhi_pkg::DEG_W-1:0]       deg_mag;
  logic signed [chhi_pkg::HEAD_W-1:0] head_mag, head_d;
  chhi_pkg::flags_t                 fo;
  chhi_pkg::out_item_t              out_d;

  always_comb begin
    fo       = fl_q[NS+2];
    z_neg    = cz_q[NS][chhi_pkg::Z_W-1];
    z_mag    = z_neg ? chhi_pkg::Z_W'(-cz_q[NS]) : chhi_pkg::Z_W'(cz_q[NS]);
    deg_mag  = z_mag[chhi_pkg::Z_W-1:chhi_pkg::FRAC_W];
    if (deg_mag > chhi_pkg::DEG_LIMIT) begin
      deg_mag = chhi_pkg::DEG_LIMIT;
    end
    head_mag = chhi_pkg::HEAD_W'(deg_mag);
    head_d   = z_neg ? -head_mag : head_mag;
    if (fo.err) begin
      out_d.heading_deg = chhi_pkg::HEAD_ZERO;
    end else if (fo.y_zero) begin
      out_d.heading_deg = fo.x_neg ? chhi_pkg::HEAD_HALF : chhi_pkg::HEAD_ZERO;
    end else begin
      out_d.heading_deg = head_d;
    end
    out_d.range_error = fo.err;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/chhi_checker.sv
// port-level checks for the compass heading block, bound to the top level
// depends on chhi_pkg and compass_heading_hard_iron_macros.svh
`default_nettype none
`include "compass_heading_hard_iron_macros.svh"

module chhi_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire chhi_pkg::out_item_t out_data_o
);

  `CHHI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "output item changed while stalled")
  `CHHI_ASSERT_NOW(a_err_zero, clk_i, rst_ni, !(out_valid_o && out_data_o.range_error) || (out_data_o.heading_deg == 9'sd0), "range error with nonzero heading")
  `CHHI_ASSERT_NOW(a_head_range, clk_i, rst_ni, !out_valid_o || ((out_data_o.heading_deg >= -9'sd180) && (out_data_o.heading_deg <= 9'sd180)), "heading out of range")
  `CHHI_ASSERT_NOW(a_in_stall, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i), "input stall does not follow output backpressure")

endmodule

bind compass_heading_hard_iron chhi_checker u_chhi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
